>>> src/gla_pkg.sv
// Shared types and codes for the grouped leaf allocator.
// Used by the channel interfaces, the output stage and the top level.
package gla_pkg;

    localparam int OP_W     = 2;
    localparam int GRP_W    = 5;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 20;
    localparam int COUNT_W  = 5;
    localparam int FREE_W   = 9;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int OFF_SLOT_W = 8;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_GROUP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_LEAF  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DBL_FREE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_SIZE = 1'b1;

    localparam logic [CFG_W-1:0] HEADER_RESET    = 16'd24;
    localparam logic [CFG_W-1:0] LEAF_SIZE_RESET = 16'd256;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [GRP_W-1:0]      leaf_group;
        logic [SLOT_W-1:0]     leaf_slot;
        logic [OFF_SLOT_W-1:0] off_slot;
        logic                  leaf_exists;
        logic                  leaf_used;
        logic                  leaf_free;
        logic [COUNT_W-1:0]    used_in_group;
        logic [FREE_W-1:0]     free_count;
        logic [GRP_W-1:0]      groups_opened;
    } t_res;

endpackage

>>> src/gla_if.sv
// Request and response channels of the grouped leaf allocator.
// Depends on gla_pkg for the field widths.
interface gla_req_if;
    logic                          valid;
    logic                          ready;
    logic [gla_pkg::OP_W-1:0]      operation;
    logic [gla_pkg::GRP_W-1:0]     group_id;
    logic [gla_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, operation, group_id, slot, input ready);
    modport sink (input valid, operation, group_id, slot, output ready);
endinterface

interface gla_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [gla_pkg::STATUS_W-1:0]  status;
    logic [gla_pkg::GRP_W-1:0]     leaf_group;
    logic [gla_pkg::SLOT_W-1:0]    leaf_slot;
    logic [gla_pkg::OFFSET_W-1:0]  byte_offset;
    logic                          leaf_exists;
    logic                          leaf_used;
    logic                          leaf_free;
    logic [gla_pkg::COUNT_W-1:0]   used_in_group;
    logic [gla_pkg::FREE_W-1:0]    free_count;
    logic [gla_pkg::GRP_W-1:0]     groups_opened;

    modport source (output valid, status, leaf_group, leaf_slot, byte_offset, leaf_exists,
                    leaf_used, leaf_free, used_in_group, free_count, groups_opened,
                    input ready);
    modport sink (input valid, status, leaf_group, leaf_slot, byte_offset, leaf_exists,
                  leaf_used, leaf_free, used_in_group, free_count, groups_opened,
                  output ready);
endinterface

>>> src/gla_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
// Holds the free stack and the group table; no dependencies.
module gla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic                   i_re,
    input  logic [AW-1:0]          i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/gla_out.sv
// Output stage: forms the byte offset and holds one response word.
// Depends on gla_pkg and gla_rsp_if.
module gla_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  gla_pkg::t_res                i_res,
    input  logic [gla_pkg::CFG_W-1:0]    i_header,
    input  logic [gla_pkg::CFG_W-1:0]    i_leaf_bytes,
    output logic                         o_can_load,
    gla_rsp_if.source                    o_rsp
);
    localparam int PROD_W = gla_pkg::OFF_SLOT_W + gla_pkg::CFG_W;

    logic                              r_valid;
    gla_pkg::t_res                     r_res;
    logic [gla_pkg::OFFSET_W-1:0]      r_offset;
    logic [PROD_W-1:0]                 w_prod;
    logic [PROD_W-1:0]                 w_sum;
    logic [gla_pkg::OFFSET_W-1:0]      n_offset;

    assign w_prod = PROD_W'(i_res.off_slot) * PROD_W'(i_leaf_bytes);
    assign w_sum  = PROD_W'(i_header) + w_prod;

    always_comb begin
        if (i_res.status == gla_pkg::ST_NO_GROUP) begin
            n_offset = '0;
        end else begin
            n_offset = w_sum[gla_pkg::OFFSET_W-1:0];
        end
    end

    assign o_can_load = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res    <= i_res;
            r_offset <= n_offset;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.status        = r_res.status;
    assign o_rsp.leaf_group    = r_res.leaf_group;
    assign o_rsp.leaf_slot     = r_res.leaf_slot;
    assign o_rsp.byte_offset   = r_offset;
    assign o_rsp.leaf_exists   = r_res.leaf_exists;
    assign o_rsp.leaf_used     = r_res.leaf_used;
    assign o_rsp.leaf_free     = r_res.leaf_free;
    assign o_rsp.used_in_group = r_res.used_in_group;
    assign o_rsp.free_count    = r_res.free_count;
    assign o_rsp.groups_opened = r_res.groups_opened;
endmodule

>>> src/grouped_leaf_allocator_unit.sv
// Grouped leaf allocator: LIFO free stack and per-group used bitmaps in two RAMs.
// Free and query read the group row and load the response register from S_UPD; allocate
// pops the stack through S_LEAF; when the stack is empty it first opens a group in S_OPEN
// (one push per cycle), then S_POP. One request is in work at a time; S_UPD waits for output.
// Reset is synchronous and active low; RAM contents are not cleared, a group's row is
// zeroed when it is opened.
module grouped_leaf_allocator_unit #(
    parameter int GROUP_LEAVES = 16,
    parameter int MAX_GROUPS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gla_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gla_pkg::CFG_W-1:0]        i_cfg_wdata,
    gla_req_if.sink                          i_req,
    gla_rsp_if.source                        o_rsp
);
    localparam int TOTAL = GROUP_LEAVES * MAX_GROUPS;
    localparam int SW    = (GROUP_LEAVES > 1) ? $clog2(GROUP_LEAVES) : 1;
    localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int SAW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int DW    = $clog2(TOTAL + 1);
    localparam int NGW   = $clog2(MAX_GROUPS + 2);
    localparam int CW    = $clog2(GROUP_LEAVES + 1);
    localparam int EW    = GW + SW;
    localparam int RW    = GROUP_LEAVES + CW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_OPEN = 5'b00010,
        S_POP  = 5'b00100,
        S_LEAF = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [gla_pkg::OP_W-1:0]        r_op, n_op;
    logic [GW-1:0]                   r_gidx, n_gidx;
    logic [SW-1:0]                   r_slot, n_slot;
    logic [gla_pkg::GRP_W-1:0]       r_out_grp, n_out_grp;
    logic [gla_pkg::SLOT_W-1:0]      r_out_slot, n_out_slot;
    logic [gla_pkg::OFF_SLOT_W-1:0]  r_off_slot, n_off_slot;
    logic                            r_grp_ok, n_grp_ok;
    logic                            r_slot_ok, n_slot_ok;
    logic                            r_nogrp, n_nogrp;
    logic [DW-1:0]                   r_depth, n_depth;
    logic [NGW-1:0]                  r_next_group, n_next_group;
    logic [SW-1:0]                   r_cnt, n_cnt;
    logic [gla_pkg::CFG_W-1:0]       r_header;
    logic [gla_pkg::CFG_W-1:0]       r_leaf_bytes;

    logic                            w_s_we, w_s_re;
    logic [SAW-1:0]                  w_s_waddr, w_s_raddr;
    logic [EW-1:0]                   w_s_wdata, w_s_rdata;
    logic                            w_g_we, w_g_re;
    logic [GW-1:0]                   w_g_waddr, w_g_raddr;
    logic [RW-1:0]                   w_g_wdata, w_g_rdata;

    logic                            w_accept;
    logic                            w_can_load, w_load;
    gla_pkg::t_res                   w_res;
    logic [31:0]                     w_in_gidx;
    logic [31:0]                     w_open_gidx;
    logic                            w_in_grp_ok, w_in_slot_ok;
    logic                            w_bit;
    logic [CW-1:0]                   w_count, w_new_count;
    logic [RW-1:0]                   w_new_row;
    logic                            w_new_bit;
    logic [gla_pkg::STATUS_W-1:0]    w_status;
    logic                            w_row_we, w_push;
    logic [DW-1:0]                   w_depth_after;

    gla_ram #(.WIDTH(EW), .DEPTH(TOTAL)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_s_waddr),
        .i_wdata (w_s_wdata),
        .i_re    (w_s_re),
        .i_raddr (w_s_raddr),
        .o_rdata (w_s_rdata)
    );

    gla_ram #(.WIDTH(RW), .DEPTH(MAX_GROUPS)) u_groups (
        .i_clk   (i_clk),
        .i_we    (w_g_we),
        .i_waddr (w_g_waddr),
        .i_wdata (w_g_wdata),
        .i_re    (w_g_re),
        .i_raddr (w_g_raddr),
        .o_rdata (w_g_rdata)
    );

    gla_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_res        (w_res),
        .i_header     (r_header),
        .i_leaf_bytes (r_leaf_bytes),
        .o_can_load   (w_can_load),
        .o_rsp        (o_rsp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);

    assign w_in_gidx    = 32'(i_req.group_id) - 32'd1;
    assign w_open_gidx  = 32'(r_next_group) - 32'd1;
    assign w_in_grp_ok  = (i_req.group_id != '0) &&
                          (32'(i_req.group_id) < 32'(r_next_group)) &&
                          (32'(i_req.group_id) <= MAX_GROUPS);
    assign w_in_slot_ok = (32'(i_req.slot) < GROUP_LEAVES);

    // Read-modify-write of the addressed group row.
    assign w_bit   = w_g_rdata[r_slot];
    assign w_count = w_g_rdata[GROUP_LEAVES +: CW];

    always_comb begin
        w_status    = gla_pkg::ST_OK;
        w_new_bit   = w_bit;
        w_new_count = w_count;
        w_row_we    = 1'b0;
        w_push      = 1'b0;
        if (r_nogrp) begin
            w_status = gla_pkg::ST_NO_GROUP;
        end else if (r_op == gla_pkg::OP_ALLOC) begin
            w_new_bit   = 1'b1;
            w_new_count = w_count + CW'(1);
            w_row_we    = 1'b1;
        end else if (r_op == gla_pkg::OP_FREE) begin
            if (!(r_grp_ok && r_slot_ok)) begin
                w_status = gla_pkg::ST_NO_LEAF;
            end else if (!w_bit) begin
                w_status = gla_pkg::ST_DBL_FREE;
            end else begin
                w_new_bit = 1'b0;
                if (w_count != '0) begin
                    w_new_count = w_count - CW'(1);
                end
                w_row_we = 1'b1;
                w_push   = (32'(r_depth) < TOTAL);
            end
        end
    end

    always_comb begin
        w_new_row                       = w_g_rdata;
        w_new_row[r_slot]               = w_new_bit;
        w_new_row[GROUP_LEAVES +: CW]   = w_new_count;
    end

    assign w_depth_after = w_push ? (r_depth + DW'(1)) : r_depth;

    always_comb begin
        w_res.status        = w_status;
        w_res.leaf_group    = r_out_grp;
        w_res.leaf_slot     = r_out_slot;
        w_res.off_slot      = r_off_slot;
        w_res.leaf_exists   = r_grp_ok && r_slot_ok;
        w_res.leaf_used     = r_grp_ok && r_slot_ok && w_new_bit;
        w_res.leaf_free     = r_grp_ok && r_slot_ok && !w_new_bit;
        w_res.used_in_group = r_grp_ok ? gla_pkg::COUNT_W'(w_new_count) : '0;
        w_res.free_count    = gla_pkg::FREE_W'(w_depth_after);
        w_res.groups_opened = gla_pkg::GRP_W'(w_open_gidx);
    end

    assign w_load = (r_state == S_UPD) && w_can_load;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_gidx       = r_gidx;
        n_slot       = r_slot;
        n_out_grp    = r_out_grp;
        n_out_slot   = r_out_slot;
        n_off_slot   = r_off_slot;
        n_grp_ok     = r_grp_ok;
        n_slot_ok    = r_slot_ok;
        n_nogrp      = r_nogrp;
        n_depth      = r_depth;
        n_next_group = r_next_group;
        n_cnt        = r_cnt;
        w_s_we       = 1'b0;
        w_s_waddr    = r_depth[SAW-1:0];
        w_s_wdata    = {r_gidx, r_slot};
        w_s_re       = 1'b0;
        w_s_raddr    = SAW'(r_depth - DW'(1));
        w_g_we       = 1'b0;
        w_g_waddr    = r_gidx;
        w_g_wdata    = w_new_row;
        w_g_re       = 1'b0;
        w_g_raddr    = w_in_gidx[GW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op       = i_req.operation;
                    n_nogrp    = 1'b0;
                    n_gidx     = w_in_gidx[GW-1:0];
                    n_slot     = SW'(i_req.slot);
                    n_out_grp  = i_req.group_id;
                    n_out_slot = i_req.slot;
                    n_off_slot = gla_pkg::OFF_SLOT_W'(i_req.slot);
                    n_grp_ok   = w_in_grp_ok;
                    n_slot_ok  = w_in_slot_ok;
                    if (i_req.operation != gla_pkg::OP_ALLOC) begin
                        w_g_re  = 1'b1;
                        n_state = S_UPD;
                    end else if (r_depth != '0) begin
                        w_s_re  = 1'b1;
                        n_depth = r_depth - DW'(1);
                        n_state = S_LEAF;
                    end else if (32'(r_next_group) > MAX_GROUPS) begin
                        n_nogrp    = 1'b1;
                        n_grp_ok   = 1'b0;
                        n_slot_ok  = 1'b0;
                        n_out_grp  = '0;
                        n_out_slot = '0;
                        n_off_slot = '0;
                        n_state    = S_UPD;
                    end else begin
                        n_cnt   = '0;
                        n_state = S_OPEN;
                    end
                end
            end
            S_OPEN: begin
                w_s_we    = 1'b1;
                w_s_waddr = SAW'(r_cnt);
                w_s_wdata = {w_open_gidx[GW-1:0], r_cnt};
                if (r_cnt == '0) begin
                    w_g_we    = 1'b1;
                    w_g_waddr = w_open_gidx[GW-1:0];
                    w_g_wdata = '0;
                end
                if (32'(r_cnt) == GROUP_LEAVES - 1) begin
                    n_depth      = DW'(GROUP_LEAVES);
                    n_next_group = r_next_group + NGW'(1);
                    n_state      = S_POP;
                end else begin
                    n_cnt = r_cnt + SW'(1);
                end
            end
            S_POP: begin
                w_s_re  = 1'b1;
                n_depth = r_depth - DW'(1);
                n_state = S_LEAF;
            end
            S_LEAF: begin
                n_gidx     = w_s_rdata[EW-1:SW];
                n_slot     = w_s_rdata[SW-1:0];
                n_out_grp  = gla_pkg::GRP_W'(32'(w_s_rdata[EW-1:SW]) + 32'd1);
                n_out_slot = gla_pkg::SLOT_W'(w_s_rdata[SW-1:0]);
                n_off_slot = gla_pkg::OFF_SLOT_W'(w_s_rdata[SW-1:0]);
                n_grp_ok   = 1'b1;
                n_slot_ok  = 1'b1;
                w_g_re     = 1'b1;
                w_g_raddr  = w_s_rdata[EW-1:SW];
                n_state    = S_UPD;
            end
            S_UPD: begin
                if (w_can_load) begin
                    w_g_we  = w_row_we;
                    w_s_we  = w_push;
                    n_depth = w_depth_after;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_depth      <= '0;
            r_next_group <= NGW'(1);
        end else begin
            r_state      <= n_state;
            r_depth      <= n_depth;
            r_next_group <= n_next_group;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_gidx     <= n_gidx;
        r_slot     <= n_slot;
        r_out_grp  <= n_out_grp;
        r_out_slot <= n_out_slot;
        r_off_slot <= n_off_slot;
        r_grp_ok   <= n_grp_ok;
        r_slot_ok  <= n_slot_ok;
        r_nogrp    <= n_nogrp;
        r_cnt      <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header     <= gla_pkg::HEADER_RESET;
            r_leaf_bytes <= gla_pkg::LEAF_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gla_pkg::CFG_HEADER:    r_header     <= i_cfg_wdata;
                gla_pkg::CFG_LEAF_SIZE: r_leaf_bytes <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end
endmodule
